// File: rtl/core/rme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation-matrix-to-Euler package
// Payload types, CORDIC angle table and shared constants.
// ----------------------------------------------------------------------------
package rme_pkg;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m10;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [15:0] m12;
        logic signed [15:0] m11;
    } rme_in_t;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic               is_singular;
    } rme_out_t;

    localparam int TABLE_LEN = 24;
    // Vector datapath: 17-bit operand * 256, grown by CORDIC gain and 24 steps.
    localparam int VW = 28;
    // Angle accumulator in 2^-15 degree.
    localparam int AW = 25;
    localparam logic signed [AW-1:0] HALF_TURN = 25'sd5898240;
    localparam logic signed [15:0] ANGLE_LIMIT = 16'sd23040;

    function automatic logic signed [AW-1:0] atan_lut(input logic [4:0] i);
        logic signed [AW-1:0] t;
        begin
            case (i)
                5'd0:  t = 25'sd1474560;
                5'd1:  t = 25'sd870484;
                5'd2:  t = 25'sd459940;
                5'd3:  t = 25'sd233473;
                5'd4:  t = 25'sd117189;
                5'd5:  t = 25'sd58652;
                5'd6:  t = 25'sd29333;
                5'd7:  t = 25'sd14667;
                5'd8:  t = 25'sd7334;
                5'd9:  t = 25'sd3667;
                5'd10: t = 25'sd1833;
                5'd11: t = 25'sd917;
                5'd12: t = 25'sd458;
                5'd13: t = 25'sd229;
                5'd14: t = 25'sd115;
                5'd15: t = 25'sd57;
                5'd16: t = 25'sd29;
                5'd17: t = 25'sd14;
                5'd18: t = 25'sd7;
                5'd19: t = 25'sd4;
                5'd20: t = 25'sd2;
                5'd21: t = 25'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

// File: rtl/core/rme_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined square root
// Floor root of a 32-bit value, two result bits per stage, with a sideband.
// ----------------------------------------------------------------------------
module rme_sqrt #(
    parameter int SW = 100
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [31:0]   in_val,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [15:0]   out_root,
    output logic [SW-1:0] out_side
);
    import rme_pkg::*;

    localparam int NS = 8;   // two root bits per stage

    logic [NS:0]   vld_reg;
    logic [31:0]   rem_reg  [NS+1];
    logic [15:0]   root_reg [NS+1];
    logic [SW-1:0] side_reg [NS+1];

    assign vld_reg[0]  = in_valid;
    assign rem_reg[0]  = in_val;
    assign root_reg[0] = '0;
    assign side_reg[0] = in_side;

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [31:0] rem_next;
        logic [15:0] root_next;
        always_comb
        begin
            logic [31:0] r;
            logic [31:0] rm;
            r  = 32'(root_reg[s]);
            rm = rem_reg[s];
            for (int k = 0; k < 2; k++) begin
                if ({2'b0, rm} >> (30 - 2*(2*s+k)) >= ((34'(r) << 2) | 34'd1)) begin
                    rm = rm - 32'(((34'(r) << 2) | 34'd1) << (30 - 2*(2*s+k)));
                    r  = (r << 1) | 32'd1;
                end else begin
                    r  = r << 1;
                end
            end
            rem_next  = rm;
            root_next = r[15:0];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= vld_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (en) begin
                rem_reg[s+1]  <= rem_next;
                root_reg[s+1] <= root_next;
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[NS];
    assign out_root  = root_reg[NS];
    assign out_side  = side_reg[NS];
endmodule

// File: rtl/core/rme_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined CORDIC atan2
// Vectoring-mode atan2 in 1/128 degree, one rotation per register stage.
// ----------------------------------------------------------------------------
module rme_cordic #(
    parameter int STAGES = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [16:0] y_in,
    input  logic signed [16:0] x_in,
    output logic signed [15:0] angle
);
    import rme_pkg::*;

    localparam int NS = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;

    logic signed [VW-1:0] x_reg [NS+1];
    logic signed [VW-1:0] y_reg [NS+1];
    logic signed [AW-1:0] a_reg [NS+1];
    logic signed [15:0]   angle_reg;

    // Prerotation into the right half plane.
    always_ff @(posedge clk)
    begin
        if (en) begin
            if (x_in < 0) begin
                x_reg[0] <= -(VW'(x_in) <<< 8);
                y_reg[0] <= -(VW'(y_in) <<< 8);
                a_reg[0] <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                x_reg[0] <= VW'(x_in) <<< 8;
                y_reg[0] <= VW'(y_in) <<< 8;
                a_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_rot
        always_ff @(posedge clk)
        begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + atan_lut(5'(i));
                end else if (y_reg[i] < 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - atan_lut(5'(i));
                end else begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    a_reg[i+1] <= a_reg[i];
                end
            end
        end
    end

    // Round to 1/128 degree and saturate.
    always_ff @(posedge clk)
    begin
        logic signed [AW-1:0] r;
        if (en) begin
            r = (a_reg[NS] + AW'(128)) >>> 8;
            if (r > AW'(ANGLE_LIMIT))
                angle_reg <= ANGLE_LIMIT;
            else if (r < -AW'(ANGLE_LIMIT))
                angle_reg <= -ANGLE_LIMIT;
            else
                angle_reg <= r[15:0];
        end
    end

    assign angle = angle_reg;
endmodule

// File: rtl/core/rotation_matrix_to_euler.sv
`timescale 1ns / 1ps
// Pipeline from input accept to result valid: squaring, sum, the root stages,
// then the CORDIC prerotation, rotation stages and rounding register.
// Throughput: one item per cycle; the whole pipe advances when the output
// register is empty or being taken.
// Reset: valid bits clear, singular_threshold returns to 1.
// ----------------------------------------------------------------------------
// Rotation matrix to XYZ Euler angles
// Square root of m00^2 + m10^2, singular select, three CORDIC atan2 pipes.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [14:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  rme_pkg::rme_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rme_pkg::rme_out_t out_data
);
    import rme_pkg::*;

    localparam int CS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int CL = CS + 2;   // CORDIC latency
    localparam int SW = 7 * 16;

    logic [14:0] thr_reg;
    logic        en;

    // Whole pipe advances together: stall only when a result waits unread.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 15'd1;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // Stage 1: capture item and square the column-0 entries.
    logic        v1_reg;
    rme_in_t     d1_reg;
    logic [31:0] sq0_reg, sq1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            d1_reg  <= in_data;
            sq0_reg <= 32'(in_data.m00 * in_data.m00);
            sq1_reg <= 32'(in_data.m10 * in_data.m10);
        end
    end

    // Stage 2: sum of squares (fits in 32 bits unsigned).
    logic        v2_reg;
    rme_in_t     d2_reg;
    logic [31:0] sum_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            d2_reg  <= d1_reg;
            sum_reg <= sq0_reg + sq1_reg;
        end
    end

    logic          v3;
    logic [15:0]   sy;
    logic [SW-1:0] side3;
    rme_in_t       d3;

    rme_sqrt #(.SW(SW)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v2_reg), .in_val(sum_reg), .in_side(d2_reg),
        .out_valid(v3), .out_root(sy), .out_side(side3)
    );
    assign d3 = side3;

    // Singular select into the CORDIC operands.
    logic               sing;
    logic signed [16:0] xy, xx, zy, zx, yy, yx;
    always_comb
    begin
        sing = {1'b0, sy} < {2'b0, thr_reg};
        yy = -17'(d3.m20);
        yx = {1'b0, sy};
        xy = sing ? -17'(d3.m12) : 17'(d3.m21);
        xx = sing ? 17'(d3.m11) : 17'(d3.m22);
        zy = sing ? 17'sd0 : 17'(d3.m10);
        zx = sing ? 17'sd0 : 17'(d3.m00);
    end

    logic signed [15:0] ax, ay, az;
    rme_cordic #(.STAGES(CS)) u_cx (.clk(clk), .en(en), .y_in(xy), .x_in(xx), .angle(ax));
    rme_cordic #(.STAGES(CS)) u_cy (.clk(clk), .en(en), .y_in(yy), .x_in(yx), .angle(ay));
    rme_cordic #(.STAGES(CS)) u_cz (.clk(clk), .en(en), .y_in(zy), .x_in(zx), .angle(az));

    // Hold valid and the singular flag alongside the CORDIC pipes.
    logic [CL-1:0] vs_reg, fs_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vs_reg <= '0;
        else if (en)
            vs_reg <= {vs_reg[CL-2:0], v3};
    end
    always_ff @(posedge clk)
    begin
        if (en)
            fs_reg <= {fs_reg[CL-2:0], sing};
    end

    assign out_valid            = vs_reg[CL-1];
    assign out_data.angle_x     = ax;
    assign out_data.angle_y     = ay;
    assign out_data.angle_z     = az;
    assign out_data.is_singular = fs_reg[CL-1];
endmodule
